// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ===== hdl/ktsu_pkg.sv =====
// Shared types and constants of the key event to terminal sequence unit.
package ktsu_pkg;

    localparam int SEQ_MAX = 6;
    localparam int LEN_W   = 3;

    typedef logic [7:0]       byte_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [15:0]      ticks_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_NAV  = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        NAV_RETURN    = 4'd0,
        NAV_TAB       = 4'd1,
        NAV_ESC       = 4'd2,
        NAV_BACKSPACE = 4'd3,
        NAV_UP        = 4'd4,
        NAV_DOWN      = 4'd5,
        NAV_RIGHT     = 4'd6,
        NAV_LEFT      = 4'd7,
        NAV_HOME      = 4'd8,
        NAV_END       = 4'd9
    } nav_t;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_DELAY  = 1'b0,
        REG_PERIOD = 1'b1
    } reg_idx_t;

    localparam ticks_t DELAY_RST  = 16'd200;
    localparam ticks_t PERIOD_RST = 16'd33;

    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_ESC   = 8'h1B;
    localparam byte_t CH_DEL   = 8'h7F;
    localparam byte_t CH_LBRK  = 8'h5B;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_TILDE = 8'h7E;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_ONE   = 8'h31;
    localparam byte_t CH_FIVE  = 8'h35;
    localparam byte_t CH_SIX   = 8'h36;
    localparam byte_t CH_UA    = 8'h41;
    localparam byte_t CH_UB    = 8'h42;
    localparam byte_t CH_UC    = 8'h43;
    localparam byte_t CH_UD    = 8'h44;
    localparam byte_t CH_UF    = 8'h46;
    localparam byte_t CH_UH    = 8'h48;
    localparam byte_t CH_UZ    = 8'h5A;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_LAST  = 8'h7E;

    localparam byte_t CASE_MASK = 8'hDF;
    localparam byte_t CTRL_MASK = 8'h1F;

    typedef struct packed {
        kind_t      kind;
        byte_t      char_code;
        logic [3:0] nav_key;
        logic       pressed;
        logic       shift_held;
        logic       alt_held;
        logic       ctrl_held;
        logic       fn_held;
        logic       key_still_down;
    } evt_t;

endpackage

// ===== hdl/ktsu_if.sv =====
// Channel interfaces: key event input and terminal byte output.
interface ktsu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [3:0] nav_key;
    logic       pressed;
    logic       shift_held;
    logic       alt_held;
    logic       ctrl_held;
    logic       fn_held;
    logic       key_still_down;

    modport source (
        output valid, kind, char_code, nav_key, pressed, shift_held, alt_held,
               ctrl_held, fn_held, key_still_down,
        input  ready
    );
    modport sink (
        input  valid, kind, char_code, nav_key, pressed, shift_held, alt_held,
               ctrl_held, fn_held, key_still_down,
        output ready
    );
endinterface

interface ktsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (
        output valid, out_byte, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_run,
        output ready
    );
endinterface

// ===== hdl/key_event_to_terminal_sequence_unit.sv =====
// Key event to terminal byte sequence encoder with typematic repeat.
//
//  channel | dir | payload                                         | handshake
//  evt     | in  | kind, char_code, nav_key, pressed, modifiers,    | valid/ready
//          |     | key_still_down                                  |
//  seq     | out | out_byte, last_of_run                           | valid/ready
//  apb     | in  | 2 x 16-bit registers at byte 0 and 4            | psel/penable
//
// An accepted word is held in the input register; the encoder then loads its
// whole sequence (1 to 6 bytes) into the output shift register in parallel.
// Bytes leave one per cycle while seq.ready is high; items giving no byte pass
// through the input register and need no output slot.
// The input register stalls only while the output shift register still holds
// bytes that will not drain this cycle. Reset clears all control state at once.
module key_event_to_terminal_sequence_unit (
    input  logic              clk,
    input  logic              rst_n,
    ktsu_in_if.sink           evt,
    ktsu_out_if.source        seq,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration
    ktsu_pkg::ticks_t delay_reg;
    ktsu_pkg::ticks_t period_reg;
    logic             cfg_wr;

    // input register
    logic           s1_valid_reg;
    ktsu_pkg::evt_t s1_reg;
    logic           s1_advance;
    logic           in_ready;

    // repeat state
    logic             repeat_on_reg,     repeat_on_next;
    logic [3:0]       repeat_key_reg,    repeat_key_next;
    ktsu_pkg::byte_t  repeat_bytes_reg [ktsu_pkg::SEQ_MAX];
    ktsu_pkg::len_t   repeat_length_reg, repeat_length_next;
    ktsu_pkg::ticks_t ticks_left_reg,    ticks_left_next;
    logic             store_seq;

    // encoder result
    ktsu_pkg::byte_t  seq_b [ktsu_pkg::SEQ_MAX];
    ktsu_pkg::len_t   seq_len;

    // output shift register
    ktsu_pkg::byte_t  obuf_reg [ktsu_pkg::SEQ_MAX];
    ktsu_pkg::len_t   rem_reg;
    logic             out_take;
    logic             out_free;
    logic             out_load;

    // helpers
    logic             mod_any;
    ktsu_pkg::byte_t  mod_char;
    ktsu_pkg::byte_t  ch_upper;
    ktsu_pkg::byte_t  cur_final;
    ktsu_pkg::byte_t  tilde_digit;
    logic             use_tilde;
    ktsu_pkg::ticks_t ticks_dec;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= ktsu_pkg::DELAY_RST;
            period_reg <= ktsu_pkg::PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            case (ktsu_pkg::reg_idx_t'(paddr[2]))
                ktsu_pkg::REG_DELAY:  delay_reg  <= pwdata[15:0];
                ktsu_pkg::REG_PERIOD: period_reg <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (ktsu_pkg::reg_idx_t'(paddr[2]))
            ktsu_pkg::REG_DELAY:  prdata = {16'b0, delay_reg};
            ktsu_pkg::REG_PERIOD: prdata = {16'b0, period_reg};
            default:              prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign out_take   = seq.valid && seq.ready;
    assign out_free   = (rem_reg == '0) || ((rem_reg == ktsu_pkg::len_t'(1)) && out_take);
    assign s1_advance = s1_valid_reg && ((seq_len == '0) || out_free);
    assign out_load   = s1_advance && (seq_len != '0);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign evt.ready  = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && evt.valid)
        begin
            s1_reg.kind           <= ktsu_pkg::kind_t'(evt.kind);
            s1_reg.char_code      <= evt.char_code;
            s1_reg.nav_key        <= evt.nav_key;
            s1_reg.pressed        <= evt.pressed;
            s1_reg.shift_held     <= evt.shift_held;
            s1_reg.alt_held       <= evt.alt_held;
            s1_reg.ctrl_held      <= evt.ctrl_held;
            s1_reg.fn_held        <= evt.fn_held;
            s1_reg.key_still_down <= evt.key_still_down;
        end
    end

    // ---------------- encoder ----------------
    assign mod_any   = s1_reg.shift_held || s1_reg.alt_held || s1_reg.ctrl_held;
    // '0' + m, m = 1 + shift + 2*alt + 4*ctrl
    assign mod_char  = ktsu_pkg::CH_ONE
                     + {5'b0, s1_reg.ctrl_held, s1_reg.alt_held, s1_reg.shift_held};
    assign ch_upper  = s1_reg.char_code & ktsu_pkg::CASE_MASK;
    assign ticks_dec = (ticks_left_reg != '0) ? ticks_left_reg - 16'd1 : '0;

    always_comb
    begin
        use_tilde   = 1'b0;
        tilde_digit = ktsu_pkg::CH_FIVE;
        cur_final   = ktsu_pkg::CH_UA;
        case (s1_reg.nav_key)
            ktsu_pkg::NAV_UP:
            begin
                use_tilde   = s1_reg.fn_held;
                tilde_digit = ktsu_pkg::CH_FIVE;
                cur_final   = ktsu_pkg::CH_UA;
            end
            ktsu_pkg::NAV_DOWN:
            begin
                use_tilde   = s1_reg.fn_held;
                tilde_digit = ktsu_pkg::CH_SIX;
                cur_final   = ktsu_pkg::CH_UB;
            end
            ktsu_pkg::NAV_RIGHT: cur_final = s1_reg.fn_held ? ktsu_pkg::CH_UF
                                                           : ktsu_pkg::CH_UC;
            ktsu_pkg::NAV_LEFT:  cur_final = s1_reg.fn_held ? ktsu_pkg::CH_UH
                                                           : ktsu_pkg::CH_UD;
            ktsu_pkg::NAV_HOME:  cur_final = ktsu_pkg::CH_UH;
            ktsu_pkg::NAV_END:   cur_final = ktsu_pkg::CH_UF;
            default:             ;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < ktsu_pkg::SEQ_MAX; i++)
        begin
            seq_b[i] = '0;
        end
        seq_len            = '0;
        store_seq          = 1'b0;
        repeat_on_next     = repeat_on_reg;
        repeat_key_next    = repeat_key_reg;
        repeat_length_next = repeat_length_reg;
        ticks_left_next    = ticks_left_reg;

        case (s1_reg.kind)
            ktsu_pkg::KIND_CHAR:
            begin
                if (s1_reg.char_code != '0)
                begin
                    if (s1_reg.ctrl_held)
                    begin
                        if (ch_upper inside {[ktsu_pkg::CH_UA:ktsu_pkg::CH_UZ]})
                        begin
                            seq_b[0] = s1_reg.char_code & ktsu_pkg::CTRL_MASK;
                            seq_len  = ktsu_pkg::len_t'(1);
                        end
                    end
                    else if (s1_reg.char_code inside
                             {[ktsu_pkg::CH_SPACE:ktsu_pkg::CH_LAST]})
                    begin
                        seq_b[0] = s1_reg.char_code;
                        seq_len  = ktsu_pkg::len_t'(1);
                    end
                end
            end

            ktsu_pkg::KIND_NAV:
            begin
                if (!s1_reg.pressed)
                begin
                    // release stops repeat only for the repeating key
                    if (repeat_on_reg && (s1_reg.nav_key == repeat_key_reg))
                    begin
                        repeat_on_next = 1'b0;
                    end
                end
                else
                begin
                    case (s1_reg.nav_key) inside
                        ktsu_pkg::NAV_RETURN:
                        begin
                            seq_b[0] = ktsu_pkg::CH_CR;
                            seq_len  = ktsu_pkg::len_t'(1);
                        end
                        ktsu_pkg::NAV_TAB:
                        begin
                            if (s1_reg.shift_held)
                            begin
                                seq_b[0] = ktsu_pkg::CH_ESC;
                                seq_b[1] = ktsu_pkg::CH_LBRK;
                                seq_b[2] = ktsu_pkg::CH_UZ;
                                seq_len  = ktsu_pkg::len_t'(3);
                            end
                            else
                            begin
                                seq_b[0] = ktsu_pkg::CH_TAB;
                                seq_len  = ktsu_pkg::len_t'(1);
                            end
                        end
                        ktsu_pkg::NAV_ESC:
                        begin
                            seq_b[0] = ktsu_pkg::CH_ESC;
                            seq_len  = ktsu_pkg::len_t'(1);
                        end
                        ktsu_pkg::NAV_BACKSPACE:
                        begin
                            seq_b[0]  = ktsu_pkg::CH_DEL;
                            seq_len   = ktsu_pkg::len_t'(1);
                            store_seq = 1'b1;
                        end
                        [ktsu_pkg::NAV_UP:ktsu_pkg::NAV_END]:
                        begin
                            store_seq = 1'b1;
                            seq_b[0]  = ktsu_pkg::CH_ESC;
                            seq_b[1]  = ktsu_pkg::CH_LBRK;
                            if (use_tilde)
                            begin
                                seq_b[2] = tilde_digit;
                                if (mod_any)
                                begin
                                    seq_b[3] = ktsu_pkg::CH_SEMI;
                                    seq_b[4] = mod_char;
                                    seq_b[5] = ktsu_pkg::CH_TILDE;
                                    seq_len  = ktsu_pkg::len_t'(6);
                                end
                                else
                                begin
                                    seq_b[3] = ktsu_pkg::CH_TILDE;
                                    seq_len  = ktsu_pkg::len_t'(4);
                                end
                            end
                            else if (mod_any)
                            begin
                                seq_b[2] = ktsu_pkg::CH_ONE;
                                seq_b[3] = ktsu_pkg::CH_SEMI;
                                seq_b[4] = mod_char;
                                seq_b[5] = cur_final;
                                seq_len  = ktsu_pkg::len_t'(6);
                            end
                            else
                            begin
                                seq_b[2] = cur_final;
                                seq_len  = ktsu_pkg::len_t'(3);
                            end
                        end
                        default: ;
                    endcase

                    if (store_seq)
                    begin
                        repeat_on_next     = 1'b1;
                        repeat_key_next    = s1_reg.nav_key;
                        repeat_length_next = seq_len;
                        ticks_left_next    = delay_reg;
                    end
                end
            end

            ktsu_pkg::KIND_TICK:
            begin
                if (repeat_on_reg)
                begin
                    ticks_left_next = ticks_dec;
                    if (ticks_dec == '0)
                    begin
                        // due: sample the live key state
                        if (!s1_reg.key_still_down)
                        begin
                            repeat_on_next = 1'b0;
                        end
                        else
                        begin
                            ticks_left_next = period_reg;
                            for (int i = 0; i < ktsu_pkg::SEQ_MAX; i++)
                            begin
                                seq_b[i] = repeat_bytes_reg[i];
                            end
                            seq_len = repeat_length_reg;
                        end
                    end
                end
            end

            default: ;
        endcase
    end

    // ---------------- repeat state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_on_reg     <= 1'b0;
            repeat_key_reg    <= '0;
            repeat_length_reg <= '0;
            ticks_left_reg    <= '0;
        end
        else if (s1_advance)
        begin
            repeat_on_reg     <= repeat_on_next;
            repeat_key_reg    <= repeat_key_next;
            repeat_length_reg <= repeat_length_next;
            ticks_left_reg    <= ticks_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && store_seq)
        begin
            for (int i = 0; i < ktsu_pkg::SEQ_MAX; i++)
            begin
                repeat_bytes_reg[i] <= seq_b[i];
            end
        end
    end

    // ---------------- output shift register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (out_load)
        begin
            rem_reg <= seq_len;
        end
        else if (out_take)
        begin
            rem_reg <= rem_reg - ktsu_pkg::len_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < ktsu_pkg::SEQ_MAX; i++)
            begin
                obuf_reg[i] <= seq_b[i];
            end
        end
        else if (out_take)
        begin
            // advance to the next byte of the run
            for (int i = 0; i < ktsu_pkg::SEQ_MAX - 1; i++)
            begin
                obuf_reg[i] <= obuf_reg[i+1];
            end
            obuf_reg[ktsu_pkg::SEQ_MAX-1] <= '0;
        end
    end

    assign seq.valid       = (rem_reg != '0);
    assign seq.out_byte    = obuf_reg[0];
    assign seq.last_of_run = (rem_reg == ktsu_pkg::len_t'(1));

endmodule

// ===== hdl/ktsu_checker.sv =====
// Port-level checker for the key event to terminal sequence unit, with its bind.
`include "assert_macros.svh"

module ktsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // input stalls only behind a pending output word
    `ASSERT_IMPLY(a_stall_needs_output, clk, rst_n, !in_ready, out_valid)

    // a run continues until its last word has gone
    `ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && out_ready && !out_last, out_valid)

    // hold a stalled output word
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))

endmodule

bind key_event_to_terminal_sequence_unit ktsu_checker u_ktsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (evt.ready),
    .out_valid (seq.valid),
    .out_ready (seq.ready),
    .out_byte  (seq.out_byte),
    .out_last  (seq.last_of_run)
);
